### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define BGC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BGC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### design/bgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and constants of the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

    // Configuration register map (word index = paddr[3:2])
    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [1:0] REG_BURST_WIN   = 2'd1;
    localparam logic [1:0] REG_CYCLE_INTVL = 2'd2;

    localparam logic [15:0] LONG_PRESS_RST  = 16'd600;
    localparam logic [15:0] BURST_WIN_RST   = 16'd300;
    localparam logic [15:0] CYCLE_INTVL_RST = 16'd2000;

    // Ramp phase lag in ms
    localparam logic [31:0] RAMP_LAG_MS = 32'd210;

    // Remainder unit: one quotient bit per cycle over a 32-bit magnitude
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Stream word widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [2:0] {
        EV_TOGGLE = 3'd1,
        EV_FULL   = 3'd2,
        EV_UP     = 3'd3,
        EV_DOWN   = 3'd4,
        EV_STOP   = 3'd5
    } ev_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PREP,
        ST_LOAD,
        ST_DIV,
        ST_RAMP,
        ST_EMIT
    } bgc_state_t;

    typedef struct packed {
        logic [15:0] long_press_ms;
        logic [15:0] burst_window_ms;
        logic [15:0] cycle_interval_ms;
    } bgc_cfg_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;   // capture input word
        logic eval;   // press / release decision
        logic prep;   // phase times
        logic conv;   // signed -> magnitude
        logic step;   // one remainder iteration
        logic ramp;   // ramp boundary decision
        logic pop;    // result word taken
    } bgc_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic ramp_need;   // ramp check required after eval
        logic ev_any_next; // queue not empty after this cycle
        logic ev_any;      // queue not empty now
        logic out_last;    // head entry is the final result
    } bgc_stat_t;

endpackage

### design/bgc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_regs
// APB configuration register bank (three 16-bit timing registers).
// ----------------------------------------------------------------------------
module bgc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bgc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output bgc_pkg::bgc_cfg_t             cfg
);

    bgc_pkg::bgc_cfg_t cfg_reg;
    bgc_pkg::bgc_cfg_t cfg_next;
    logic              wr_en;
    logic [1:0]        widx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign widx   = paddr[3:2];

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (widx)
                bgc_pkg::REG_LONG_PRESS:  cfg_next.long_press_ms     = pwdata[15:0];
                bgc_pkg::REG_BURST_WIN:   cfg_next.burst_window_ms   = pwdata[15:0];
                bgc_pkg::REG_CYCLE_INTVL: cfg_next.cycle_interval_ms = pwdata[15:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ms     <= bgc_pkg::LONG_PRESS_RST;
            cfg_reg.burst_window_ms   <= bgc_pkg::BURST_WIN_RST;
            cfg_reg.cycle_interval_ms <= bgc_pkg::CYCLE_INTVL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (widx)
            bgc_pkg::REG_LONG_PRESS:  prdata = {16'd0, cfg_reg.long_press_ms};
            bgc_pkg::REG_BURST_WIN:   prdata = {16'd0, cfg_reg.burst_window_ms};
            bgc_pkg::REG_CYCLE_INTVL: prdata = {16'd0, cfg_reg.cycle_interval_ms};
            default:                  prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### design/bgc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_ctrl
// Sequencer: eval, optional ramp phase remainder loop, result emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  bgc_pkg::bgc_stat_t stat,
    output bgc_pkg::bgc_cmd_t  cmd
);

    bgc_pkg::bgc_state_t              state_reg;
    bgc_pkg::bgc_state_t              state_next;
    logic [bgc_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [bgc_pkg::DIV_CNT_W-1:0]    cnt_next;
    logic                             cnt_last;

    localparam logic [bgc_pkg::DIV_CNT_W-1:0] CNT_MAX =
        bgc_pkg::DIV_CNT_W'(bgc_pkg::DIV_STEPS - 1);

    assign cnt_last = (cnt_reg == CNT_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bgc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            bgc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bgc_pkg::ST_EVAL;
                end
            end
            bgc_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (stat.ramp_need)
                    state_next = bgc_pkg::ST_PREP;
                else if (stat.ev_any_next)
                    state_next = bgc_pkg::ST_EMIT;
                else
                    state_next = bgc_pkg::ST_IDLE;
            end
            bgc_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = bgc_pkg::ST_LOAD;
            end
            bgc_pkg::ST_LOAD:
            begin
                cmd.conv   = 1'b1;
                cnt_next   = '0;
                state_next = bgc_pkg::ST_DIV;
            end
            bgc_pkg::ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                    state_next = bgc_pkg::ST_RAMP;
            end
            bgc_pkg::ST_RAMP:
            begin
                cmd.ramp = 1'b1;
                if (stat.ev_any_next)
                    state_next = bgc_pkg::ST_EMIT;
                else
                    state_next = bgc_pkg::ST_IDLE;
            end
            bgc_pkg::ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    cmd.pop = 1'b1;
                    if (stat.out_last)
                        state_next = bgc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bgc_pkg::ST_IDLE;
            end
        endcase
    end

    // Checks
    `BGC_ASSERT(a_no_overlap, !(s_tready && m_tvalid), "input and output open together")
    `BGC_ASSERT_IMPL(a_emit_has_word, m_tvalid, stat.ev_any, "emitting from empty queue")

endmodule

### design/bgc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_dpath
// Gesture state, phase remainder lanes and a two-entry result queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgc_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bgc_pkg::bgc_cmd_t                  cmd,
    input  bgc_pkg::bgc_cfg_t                  cfg,
    input  logic [bgc_pkg::IN_TDATA_W-1:0]     s_tdata,
    output bgc_pkg::bgc_stat_t                 stat,
    output logic [bgc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast
);

    // Captured sample (payload)
    logic [31:0] now_reg;
    logic        level_reg;

    // Gesture state
    logic        held_reg,          held_next;
    logic [31:0] press_start_reg,   press_start_next;
    logic        long_active_reg,   long_active_next;
    logic        short_pending_reg, short_pending_next;
    logic [31:0] last_short_reg,    last_short_next;
    logic        short_seen_reg,    short_seen_next;
    logic        group_on_reg,      group_on_next;

    // Remainder lanes: a = phase time, b = lagged phase time
    logic [31:0] dvd_a_reg, dvd_b_reg;
    logic [16:0] rem_a_reg, rem_b_reg;
    logic        neg_a_reg, neg_b_reg;

    // Result queue
    bgc_pkg::ev_code_t ev_code_reg [2];
    logic              ev_light_reg [2];
    logic [1:0]        ev_cnt_reg,  ev_cnt_next;
    logic              head_reg,    head_next;

    // Eval intermediates
    logic [31:0] d_press;
    logic [31:0] d_short;
    logic        long_hit;
    logic        lst_pos;
    logic        burst_hit;
    logic        seen;
    logic        app_valid;
    bgc_pkg::ev_code_t app_code;
    logic        app_light;

    // Remainder step intermediates
    logic [16:0] dd;
    logic [17:0] sh_a, sh_b;
    logic        ge_a, ge_b;

    // Ramp intermediates
    logic        phase_low;
    logic        ramp_up;
    logic        ramp_down;

    logic [31:0] tu;
    logic [31:0] tl;

    // Time differences (wrapped, signed)
    assign d_press  = now_reg - (held_reg ? press_start_reg : now_reg);
    assign long_hit = !d_press[31] && (d_press > {16'd0, cfg.long_press_ms});
    assign d_short  = now_reg - last_short_reg;
    assign lst_pos  = !last_short_reg[31] && (last_short_reg != 32'd0);
    assign burst_hit = d_short[31] || (d_short < {16'd0, cfg.burst_window_ms});
    assign seen     = short_seen_reg || (lst_pos && burst_hit);

    // Phase times
    assign tu = now_reg - press_start_reg - {16'd0, cfg.long_press_ms};
    assign tl = now_reg - press_start_reg - ({16'd0, cfg.long_press_ms} + bgc_pkg::RAMP_LAG_MS);

    // Restoring remainder step, divisor 2 * cycle interval
    assign dd   = {cfg.cycle_interval_ms, 1'b0};
    assign sh_a = {rem_a_reg, dvd_a_reg[31]};
    assign sh_b = {rem_b_reg, dvd_b_reg[31]};
    assign ge_a = (sh_a >= {1'b0, dd});
    assign ge_b = (sh_b >= {1'b0, dd});

    // Truncating remainder compares: a negative dividend gives a result <= 0
    assign phase_low = neg_a_reg || (rem_a_reg < {1'b0, cfg.cycle_interval_ms});
    assign ramp_up   = phase_low && !neg_b_reg && (rem_b_reg > {1'b0, cfg.cycle_interval_ms});
    assign ramp_down = !phase_low &&
                       (neg_b_reg || (rem_b_reg < {1'b0, cfg.cycle_interval_ms}));

    // Gesture decision and queue append
    always_comb
    begin
        held_next          = held_reg;
        press_start_next   = press_start_reg;
        long_active_next   = long_active_reg;
        short_pending_next = short_pending_reg;
        last_short_next    = last_short_reg;
        short_seen_next    = short_seen_reg;
        group_on_next      = group_on_reg;
        app_valid          = 1'b0;
        app_code           = bgc_pkg::EV_UP;
        app_light          = 1'b1;

        if (cmd.eval)
        begin
            if (level_reg)
            begin
                held_next = 1'b1;
                if (!held_reg)
                    press_start_next = now_reg;
                if (long_hit && !long_active_reg)
                begin
                    long_active_next = 1'b1;
                    group_on_next    = 1'b1;
                    app_valid        = 1'b1;
                    app_code         = bgc_pkg::EV_UP;
                end
            end
            else if (held_reg)
            begin
                held_next          = 1'b0;
                short_pending_next = 1'b0;
                if (long_active_reg)
                begin
                    long_active_next = 1'b0;
                    group_on_next    = 1'b1;
                    app_valid        = 1'b1;
                    app_code         = bgc_pkg::EV_STOP;
                end
                else if (seen)
                begin
                    short_seen_next = 1'b0;
                    group_on_next   = 1'b1;
                    app_valid       = 1'b1;
                    app_code        = bgc_pkg::EV_FULL;
                end
                else
                begin
                    short_seen_next    = seen;
                    last_short_next    = now_reg;
                    short_pending_next = 1'b1;
                end
            end
            else if (short_pending_reg && lst_pos && !d_short[31] &&
                     (d_short > {16'd0, cfg.burst_window_ms}))
            begin
                // lone short press, window expired
                short_pending_next = 1'b0;
                group_on_next      = !group_on_reg;
                app_valid          = 1'b1;
                app_code           = bgc_pkg::EV_TOGGLE;
                app_light          = !group_on_reg;
            end
        end
        else if (cmd.ramp && (ramp_up || ramp_down))
        begin
            group_on_next = 1'b1;
            app_valid     = 1'b1;
            app_code      = ramp_up ? bgc_pkg::EV_UP : bgc_pkg::EV_DOWN;
        end
    end

    // Queue pointers
    always_comb
    begin
        ev_cnt_next = ev_cnt_reg;
        head_next   = head_reg;
        if (app_valid)
            ev_cnt_next = ev_cnt_reg + 2'd1;
        if (cmd.pop)
        begin
            if (stat.out_last)
            begin
                ev_cnt_next = 2'd0;
                head_next   = 1'b0;
            end
            else
            begin
                head_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg          <= 1'b0;
            press_start_reg   <= 32'd0;
            long_active_reg   <= 1'b0;
            short_pending_reg <= 1'b0;
            last_short_reg    <= 32'd0;
            short_seen_reg    <= 1'b0;
            group_on_reg      <= 1'b0;
            ev_cnt_reg        <= 2'd0;
            head_reg          <= 1'b0;
        end
        else
        begin
            held_reg          <= held_next;
            press_start_reg   <= press_start_next;
            long_active_reg   <= long_active_next;
            short_pending_reg <= short_pending_next;
            last_short_reg    <= last_short_next;
            short_seen_reg    <= short_seen_next;
            group_on_reg      <= group_on_next;
            ev_cnt_reg        <= ev_cnt_next;
            head_reg          <= head_next;
        end
    end

    // Payload registers: sample, remainder lanes, queue entries
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg   <= s_tdata[31:0];
            level_reg <= s_tdata[32];
        end
        if (app_valid)
        begin
            ev_code_reg[ev_cnt_reg[0]]  <= app_code;
            ev_light_reg[ev_cnt_reg[0]] <= app_light;
        end
        if (cmd.prep)
        begin
            dvd_a_reg <= tu;
            dvd_b_reg <= tl;
        end
        else if (cmd.conv)
        begin
            neg_a_reg <= dvd_a_reg[31];
            neg_b_reg <= dvd_b_reg[31];
            dvd_a_reg <= dvd_a_reg[31] ? (~dvd_a_reg + 32'd1) : dvd_a_reg;
            dvd_b_reg <= dvd_b_reg[31] ? (~dvd_b_reg + 32'd1) : dvd_b_reg;
            rem_a_reg <= 17'd0;
            rem_b_reg <= 17'd0;
        end
        else if (cmd.step)
        begin
            dvd_a_reg <= {dvd_a_reg[30:0], 1'b0};
            dvd_b_reg <= {dvd_b_reg[30:0], 1'b0};
            rem_a_reg <= ge_a ? 17'(sh_a - {1'b0, dd}) : sh_a[16:0];
            rem_b_reg <= ge_b ? 17'(sh_b - {1'b0, dd}) : sh_b[16:0];
        end
    end

    // Status
    assign stat.ramp_need   = long_active_next && (cfg.cycle_interval_ms != 16'd0);
    assign stat.ev_any_next = (ev_cnt_next != 2'd0);
    assign stat.ev_any      = (ev_cnt_reg != 2'd0);
    assign stat.out_last    = (({1'b0, head_reg} + 2'd1) == ev_cnt_reg);

    // Output word: event code, light state
    assign m_tdata = {4'd0, ev_light_reg[head_reg], ev_code_reg[head_reg]};
    assign m_tlast = stat.out_last;

    // Checks
    `BGC_ASSERT(a_queue_depth, ev_cnt_reg != 2'd3, "result queue overflow")
    `BGC_ASSERT_IMPL(a_long_needs_held, long_active_reg, held_reg, "long press without hold")

endmodule

### design/button_gesture_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_classifier_core
// Classifies button samples into toggle, full, ramp up/down/stop events.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------
//  s_*     | in  | s_tvalid / s_tready | time_ms, button_level
//  m_*     | out | m_tvalid / m_tready | event_res, light_on; tlast = last
//  apb     | in  | psel & penable      | 16-bit timing registers at 0,4,8
//
//  One sample at a time. Eval follows acceptance; while a long press is
//  active and the cycle interval is nonzero, phase setup (prep, convert) and
//  the 32-step remainder loop follow, then the ramp check. Result words are
//  then emitted one at a time from the result queue.
//  A stalled m_tready holds the word and blocks the next sample.
//  Reset (rst_n, async) clears all gesture state and loads register defaults.
// ----------------------------------------------------------------------------
module button_gesture_classifier_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // time_ms [31:0], button_level [32], zero pad [39:33]
    input  logic [bgc_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // event_res [2:0], light_on [3], zero pad [7:4]
    output logic [bgc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bgc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    bgc_pkg::bgc_cfg_t  cfg;
    bgc_pkg::bgc_cmd_t  cmd;
    bgc_pkg::bgc_stat_t stat;

    bgc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bgc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bgc_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .cfg     (cfg),
        .s_tdata (s_tdata),
        .stat    (stat),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule
